// ===== src/brm_pkg.sv =====
// ----------------------------------------------------------------------------
// brm_pkg
// Shared constants and types for the radix-2 Booth multiplier core.
// ----------------------------------------------------------------------------
`default_nettype none

package brm_pkg;

    // operand register width in cells; legal range 2..32
    localparam int WIDTH   = 16;
    localparam int CNT_W   = $clog2(WIDTH + 1);
    localparam int PROD_W  = 2 * WIDTH;

    // fixed field widths of the stream payload
    localparam int OPND_W  = 16;
    localparam int WIU_W   = 5;
    localparam int MAG_W   = 31;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic load;     // take fresh operands, clear accumulator
        logic step;     // one Booth add/sub + shift
        logic do_op;    // add or subtract the multiplicand this step
        logic sub_op;   // 1 = subtract
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

`default_nettype wire

// ===== src/brm_cell.sv =====
// ----------------------------------------------------------------------------
// brm_cell
// One bit slice: accumulator, multiplier and multiplicand bits, a full adder
// and the shift mux that takes the neighbor's bits on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_cell (
    input  wire                  aclk,
    input  wire brm_pkg::cell_ctrl_t ctrl,
    input  wire                  m_in,
    input  wire                  q_in,
    input  wire                  active,     // cell lies below the width in use
    input  wire                  top,        // cell is the sign bit of the width
    input  wire                  carry_in,
    input  wire                  right_sum,  // neighbor's new accumulator bit
    input  wire                  right_q,    // neighbor's multiplier bit
    input  wire                  lsb_sum,    // new accumulator bit of cell 0
    output logic                 carry_out,
    output logic                 sum,
    output logic                 a_bit,
    output logic                 q_bit
);
    import brm_pkg::*;

    logic a_reg, a_next;
    logic q_reg, q_next;
    logic m_reg, m_next;
    logic b;

    always_comb begin
        b         = (m_reg ^ ctrl.sub_op) & ctrl.do_op;
        sum       = a_reg ^ b ^ carry_in;
        carry_out = (a_reg & b) | (carry_in & (a_reg ^ b));
    end

    always_comb begin
        a_next = a_reg;
        q_next = q_reg;
        m_next = m_reg;
        if (ctrl.load) begin
            a_next = 1'b0;
            q_next = q_in;
            m_next = m_in;
        end else if (ctrl.step) begin
            if (!active) begin
                a_next = 1'b0;
                q_next = 1'b0;
            end else if (top) begin
                // arithmetic shift: sign stays, accumulator lsb enters multiplier
                a_next = sum;
                q_next = lsb_sum;
            end else begin
                a_next = right_sum;
                q_next = right_q;
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        q_reg <= q_next;
        m_reg <= m_next;
    end

    assign a_bit = a_reg;
    assign q_bit = q_reg;

endmodule

`default_nettype wire

// ===== src/brm_cell_row.sv =====
// ----------------------------------------------------------------------------
// brm_cell_row
// Row of WIDTH Booth cells with the ripple carry running up and the shift
// running down the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module brm_cell_row (
    input  wire                          aclk,
    input  wire brm_pkg::cell_ctrl_t     ctrl,
    input  wire [brm_pkg::WIDTH-1:0]     m_load,
    input  wire [brm_pkg::WIDTH-1:0]     q_load,
    input  wire [brm_pkg::WIDTH-1:0]     active,
    input  wire [brm_pkg::WIDTH-1:0]     top,
    output logic [brm_pkg::WIDTH-1:0]    a_vec,
    output logic [brm_pkg::WIDTH-1:0]    q_vec
);
    import brm_pkg::*;

    logic [WIDTH:0]   carry;
    logic [WIDTH-1:0] sum_vec;
    logic [WIDTH-1:0] right_sum;
    logic [WIDTH-1:0] right_q;

    assign carry[0] = ctrl.do_op & ctrl.sub_op;

    always_comb begin
        right_sum = {1'b0, sum_vec[WIDTH-1:1]};
        right_q   = {1'b0, q_vec[WIDTH-1:1]};
    end

    for (genvar i = 0; i < WIDTH; i++) begin : g_cell
        brm_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .m_in      (m_load[i]),
            .q_in      (q_load[i]),
            .active    (active[i]),
            .top       (top[i]),
            .carry_in  (carry[i]),
            .right_sum (right_sum[i]),
            .right_q   (right_q[i]),
            .lsb_sum   (sum_vec[0]),
            .carry_out (carry[i+1]),
            .sum       (sum_vec[i]),
            .a_bit     (a_vec[i]),
            .q_bit     (q_vec[i])
        );
    end

endmodule

`default_nettype wire

// ===== src/booth_radix2_multiplier_core.sv =====
// A request is taken only in idle, so a new one waits until the previous product is done.
// The Booth cell row retires one multiplier bit per cycle of the run, and a single
// sign/magnitude stage follows, which waits while the output register holds an untaken result.
// A new request is taken while the previous result waits in the output register.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_core
// Radix-2 Booth signed multiplier on stream channels, built as a row of
// bit-slice cells stepped by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module booth_radix2_multiplier_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // [15:0] multiplicand, [31:16] multiplier, [36:32] width_in_use, [39:37] zero
    input  wire [brm_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [30:0] product_magnitude, [31] product_negative
    output logic [brm_pkg::M_DATA_W-1:0]      m_tdata
);
    import brm_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               qe_reg, qe_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               s_accept;
    logic [WIU_W-1:0]   wiu;
    logic [CNT_W-1:0]   n_in;
    logic [WIDTH-1:0]   mask_in;
    logic [WIDTH-1:0]   active;
    logic [WIDTH-1:0]   top;
    logic [WIDTH-1:0]   a_vec, q_vec;
    logic [WIDTH-1:0]   m_load, q_load;
    cell_ctrl_t         ctrl;
    logic               out_free;
    logic               neg;
    logic [WIDTH-1:0]   a_sx;
    logic [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]  mag;
    logic [PROD_W+MAG_W-1:0] mag_wide;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // width clamp: zero reads as one, above WIDTH saturates
    always_comb begin
        wiu = s_tdata[2*OPND_W +: WIU_W];
        if (wiu == '0)
            n_in = CNT_W'(1);
        else if (32'(wiu) > WIDTH)
            n_in = CNT_W'(WIDTH);
        else
            n_in = CNT_W'(wiu);
    end

    always_comb begin
        for (int i = 0; i < WIDTH; i++) begin
            mask_in[i] = (i < 32'(n_in));
            active[i]  = (i < 32'(n_reg));
            top[i]     = (i == 32'(n_reg) - 1);
        end
        m_load = WIDTH'(s_tdata[OPND_W-1:0]) & mask_in;
        q_load = WIDTH'(s_tdata[2*OPND_W-1:OPND_W]) & mask_in;
    end

    // Booth pair {q0, extra}: 10 subtract, 01 add
    always_comb begin
        ctrl.load   = s_accept;
        ctrl.step   = (state_reg == ST_RUN);
        ctrl.do_op  = (state_reg == ST_RUN) && (q_vec[0] != qe_reg);
        ctrl.sub_op = q_vec[0];
    end

    brm_cell_row u_row (
        .aclk   (aclk),
        .ctrl   (ctrl),
        .m_load (m_load),
        .q_load (q_load),
        .active (active),
        .top    (top),
        .a_vec  (a_vec),
        .q_vec  (q_vec)
    );

    // sign/magnitude of the 2n-bit product {a, q}
    always_comb begin
        neg      = |(a_vec & top);
        a_sx     = a_vec | (neg ? ~active : '0);
        prod     = ({{WIDTH{neg}}, a_sx} << n_reg) | PROD_W'(q_vec);
        mag      = neg ? (PROD_W'(0) - prod) : prod;
        mag_wide = (PROD_W+MAG_W)'(mag);
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        qe_next       = qe_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    n_next     = n_in;
                    cnt_next   = '0;
                    qe_next    = 1'b0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                qe_next  = q_vec[0];
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_next == n_reg)
                    state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {neg, mag_wide[MAG_W-1:0]};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            n_reg        <= CNT_W'(1);
            qe_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            n_reg        <= n_next;
            qe_reg       <= qe_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_cnt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RUN |-> cnt_reg < n_reg)
        else $error("step count ran past the width in use");

    a_width_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> (n_reg != '0) && (32'(n_reg) <= WIDTH))
        else $error("width in use outside 1..WIDTH");

    a_start_run: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_RUN && cnt_reg == '0 && !qe_reg)
        else $error("request did not start a fresh run");

    a_hold_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && m_tvalid_reg && !m_tready |=> state_reg == ST_DONE)
        else $error("result written over a stalled output");

    a_upper_cells_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE |-> ((a_vec | q_vec) & ~active) == '0)
        else $error("cells above the width in use are not clear");

endmodule

`default_nettype wire

// ===== bench/booth_radix2_multiplier_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// booth_radix2_multiplier_core_test
// Self-checking bench for the radix-2 Booth multiplier core. Each accepted
// request is run through a bit-level Booth predictor, and each product on the
// result channel is checked in order, field by field. Directed corner cases
// are followed by random requests under varying backpressure on both sides.
// ----------------------------------------------------------------------------

class booth_scoreboard;

    // predictor state, mirrors the core's registers after the last request
    logic [brm_pkg::WIDTH-1:0] acc_q;
    logic [brm_pkg::WIDTH-1:0] mplr_q;
    logic                      ext_q;
    logic [4:0]                steps_q;

    logic [brm_pkg::M_DATA_W-1:0] product_q[$];
    int mismatches;

    function new();
        acc_q      = '0;
        mplr_q     = '0;
        ext_q      = 1'b0;
        steps_q    = '0;
        mismatches = 0;
    endfunction

    // runs the Booth add/sub + shift chain at the width in use
    function logic [brm_pkg::M_DATA_W-1:0] booth_product(logic [brm_pkg::S_DATA_W-1:0] req);
        int unsigned n;
        logic [63:0] mask, mask2, m, a, q, prod, mag;
        logic qe, q0, a_top, a_low, neg;
        n = req[36:32];
        if (n == 0) n = 1;
        if (n > brm_pkg::WIDTH) n = brm_pkg::WIDTH;
        mask  = (64'd1 << n) - 64'd1;
        mask2 = (64'd1 << (2 * n)) - 64'd1;
        m  = {48'd0, req[15:0]} & mask;
        q  = {48'd0, req[31:16]} & mask;
        a  = '0;
        qe = 1'b0;
        steps_q = '0;
        for (int i = 0; i < n; i++) begin
            q0 = q[0];
            if (q0 && !qe)
                a = (a - m) & mask;
            else if (!q0 && qe)
                a = (a + m) & mask;
            a_top = a[n-1];
            a_low = a[0];
            qe = q0;
            q = ((q >> 1) | (64'(a_low) << (n - 1))) & mask;
            a = ((a >> 1) | (64'(a_top) << (n - 1))) & mask;
            steps_q = steps_q + 5'd1;
        end
        acc_q  = a[brm_pkg::WIDTH-1:0];
        mplr_q = q[brm_pkg::WIDTH-1:0];
        ext_q  = qe;
        prod = ((a << n) | q) & mask2;
        neg  = prod[2*n-1];
        mag  = neg ? ((64'd0 - prod) & mask2) : prod;
        return {neg, mag[brm_pkg::MAG_W-1:0]};
    endfunction

    function void note_request(logic [brm_pkg::S_DATA_W-1:0] req);
        product_q.push_back(booth_product(req));
    endfunction

    function void check_product(logic [brm_pkg::M_DATA_W-1:0] got);
        logic [brm_pkg::M_DATA_W-1:0] exp;
        if (product_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: product with no request pending: neg=%0b mag=0x%08h",
                         $realtime, got[31], got[30:0]);
            return;
        end
        exp = product_q.pop_front();
        if (got[30:0] !== exp[30:0] || got[31] !== exp[31]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: product mismatch: exp neg=%0b mag=0x%08h, got neg=%0b mag=0x%08h",
                         $realtime, exp[31], exp[30:0], got[31], got[30:0]);
        end
    endfunction

    function int pending();
        return product_q.size();
    endfunction

endclass

module booth_radix2_multiplier_core_test;

    import brm_pkg::*;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [15:0] multiplicand, [31:16] multiplier,
                                    // [36:32] width_in_use, [39:37] zero
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [30:0] product_magnitude, [31] product_negative

    int src_idle_pct;
    int rcv_idle_pct;

    booth_scoreboard sb = new();

    booth_radix2_multiplier_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result-side backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_request(s_tdata);
            if (m_tvalid && m_tready) sb.check_product(m_tdata);
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_request(logic [15:0] mcand,
                                                         logic [15:0] mplr,
                                                         logic [4:0]  wiu);
        return {3'b000, wiu, mplr, mcand};
    endfunction

    // operand pattern at width n, with random junk above the width now and then
    function automatic logic [15:0] pick_operand(int unsigned n);
        logic [15:0] mask, v;
        mask = 16'((32'd1 << n) - 1);
        case ($urandom_range(9))
            0:       v = 16'(32'd1 << (n - 1));          // most negative
            1:       v = 16'((32'd1 << (n - 1)) - 1);    // most positive
            2:       v = 16'hFFFF;                       // -1
            3:       v = 16'h0000;
            4:       v = 16'h0001;
            default: v = 16'($urandom);
        endcase
        v = v & mask;
        if ($urandom_range(3) == 0) v = v | (16'($urandom) & ~mask);
        return v;
    endfunction

    task automatic send_request(input logic [S_DATA_W-1:0] req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random(input int count);
        int unsigned n;
        logic [4:0] wiu;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(19))
                0:       wiu = 5'd0;
                1:       wiu = 5'($urandom_range(31, 17));
                default: wiu = 5'($urandom_range(16, 1));
            endcase
            n = (wiu == 0) ? 1 : ((wiu > WIDTH) ? WIDTH : wiu);
            send_request(pack_request(pick_operand(n), pick_operand(n), wiu));
        end
    endtask

    initial begin
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        m_tready     <= 1'b0;
        aresetn      <= 1'b0;
        src_idle_pct = 7;
        rcv_idle_pct = 60;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners at full width
        send_request(pack_request(16'h7FFF, 16'h7FFF, 5'd16));
        send_request(pack_request(16'h8000, 16'h8000, 5'd16));
        send_request(pack_request(16'h8000, 16'h7FFF, 5'd16));
        send_request(pack_request(16'h7FFF, 16'h8000, 5'd16));
        send_request(pack_request(16'hFFFF, 16'hFFFF, 5'd16));
        send_request(pack_request(16'h8000, 16'hFFFF, 5'd16));
        send_request(pack_request(16'h0000, 16'hFFFF, 5'd16));
        send_request(pack_request(16'hA5C3, 16'h0000, 5'd16));
        send_request(pack_request(16'h5555, 16'hAAAA, 5'd16));
        // one-bit operands
        send_request(pack_request(16'h0000, 16'h0000, 5'd1));
        send_request(pack_request(16'h0001, 16'h0000, 5'd1));
        send_request(pack_request(16'h0000, 16'h0001, 5'd1));
        send_request(pack_request(16'h0001, 16'h0001, 5'd1));
        // zero width acts as one bit, oversize width clamps to full
        send_request(pack_request(16'hFFFF, 16'hFFFF, 5'd0));
        send_request(pack_request(16'h8001, 16'h7FFE, 5'd17));
        send_request(pack_request(16'h8000, 16'h8000, 5'd31));
        // junk above the width must be ignored
        send_request(pack_request(16'hFFF3, 16'hABC5, 5'd4));
        send_request(pack_request(16'hFF80, 16'h12FF, 5'd8));
        // wrapped negate of the most negative multiplicand
        send_request(pack_request(16'h0080, 16'h00FF, 5'd8));
        send_request(pack_request(16'h0080, 16'h0001, 5'd8));
        send_request(pack_request(16'h0002, 16'h0003, 5'd2));
        send_request(pack_request(16'h4000, 16'h4000, 5'd15));

        send_random(440);
        src_idle_pct = 60;
        rcv_idle_pct = 7;
        send_random(440);
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        send_random(440);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (2 * WIDTH + 8) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
